FILE: design/scatr_pkg.sv
`default_nettype none

package scatr_pkg;

	localparam int MAX_ATR_BYTES_DEF = 64;

	// width of the expected-length compare: 2 + 127 + 15 + 1 fits in 9 bits
	localparam int LEN_W = 9;

	localparam logic [3:0] KIND_TS      = 4'd0;
	localparam logic [3:0] KIND_T0      = 4'd1;
	localparam logic [3:0] KIND_TA      = 4'd2;
	localparam logic [3:0] KIND_TB      = 4'd3;
	localparam logic [3:0] KIND_TC      = 4'd4;
	localparam logic [3:0] KIND_TD      = 4'd5;
	localparam logic [3:0] KIND_HIST    = 4'd6;
	localparam logic [3:0] KIND_CHECK   = 4'd7;
	localparam logic [3:0] KIND_SURPLUS = 4'd8;

	localparam logic [7:0] TS_DIRECT   = 8'h3b;
	localparam logic [7:0] TA1_DEFAULT = 8'h11;
	localparam logic [3:0] PROTO_T0    = 4'd0;
	localparam logic [3:0] PROTO_T15   = 4'd15;
	localparam logic [5:0] GROUP_MAX   = 6'd63;
	localparam logic [6:0] IFACE_MAX   = 7'd127;

	typedef struct packed {
		logic [3:0]  byte_kind;
		logic [5:0]  group_index;
		logic        summary_valid;
		logic        direct_convention;
		logic        check_required;
		logic        checksum_good;
		logic        length_good;
		logic        offers_t0;
		logic        offers_t15;
		logic [3:0]  historical_count;
		logic [11:0] clock_rate_factor;
		logic [6:0]  baud_adjust_factor;
	} result_t;

	function automatic logic [11:0] fi_decode(input logic [3:0] code);
		logic [11:0] fi;
		case (code)
			4'd0:    fi = 12'd372;
			4'd1:    fi = 12'd372;
			4'd2:    fi = 12'd558;
			4'd3:    fi = 12'd744;
			4'd4:    fi = 12'd1116;
			4'd5:    fi = 12'd1488;
			4'd6:    fi = 12'd1860;
			4'd9:    fi = 12'd512;
			4'd10:   fi = 12'd768;
			4'd11:   fi = 12'd1024;
			4'd12:   fi = 12'd1536;
			4'd13:   fi = 12'd2048;
			default: fi = 12'd0;
		endcase
		return fi;
	endfunction

	function automatic logic [6:0] di_decode(input logic [3:0] code);
		logic [6:0] di;
		case (code)
			4'd1:    di = 7'd1;
			4'd2:    di = 7'd2;
			4'd3:    di = 7'd4;
			4'd4:    di = 7'd8;
			4'd5:    di = 7'd16;
			4'd6:    di = 7'd32;
			4'd7:    di = 7'd64;
			4'd8:    di = 7'd12;
			4'd9:    di = 7'd20;
			default: di = 7'd0;
		endcase
		return di;
	endfunction

endpackage

`default_nettype wire

FILE: design/scatr_core.sv
`default_nettype none

module scatr_core #(
	parameter int MAX_ATR_BYTES = scatr_pkg::MAX_ATR_BYTES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                take,
	input  wire logic [7:0]          atr_byte,
	input  wire logic                last_byte,
	output scatr_pkg::result_t       res
);

	localparam int CNT_W = $clog2(MAX_ATR_BYTES + 1);
	localparam int LEN_W = scatr_pkg::LEN_W;

	typedef enum logic [4:0] {
		PH_TS    = 5'b00001,
		PH_T0    = 5'b00010,
		PH_IFACE = 5'b00100,
		PH_HIST  = 5'b01000,
		PH_TAIL  = 5'b10000
	} phase_t;

	logic [CNT_W-1:0] cnt_q, cnt_n;
	phase_t           phase_q, phase_n;
	logic [3:0]       pend_q, pend_n;
	logic [5:0]       grp_q, grp_n;
	logic [3:0]       hleft_q, hleft_n;
	logic [3:0]       htotal_q, htotal_n;
	logic [6:0]       iface_q, iface_n;
	logic [7:0]       xor_q, xor_n;
	logic             t0_q, t0_n;
	logic             t15_q, t15_n;
	logic [7:0]       ta1_q, ta1_n;
	logic             conv_q, conv_n;

	logic [LEN_W-1:0] exp_q, exp_n, cnt_ext, cnt_n_ext;
	logic [3:0]       proto;
	logic             req_q;
	logic [3:0]       pend_iface;

	assign exp_q     = LEN_W'(2) + LEN_W'(iface_q) + LEN_W'(htotal_q);
	assign cnt_ext   = LEN_W'(cnt_q);
	assign req_q     = !t0_q || t15_q;
	assign proto     = atr_byte[3:0];

	always_comb begin
		cnt_n     = cnt_q;
		phase_n   = phase_q;
		pend_n    = pend_q;
		grp_n     = grp_q;
		hleft_n   = hleft_q;
		htotal_n  = htotal_q;
		iface_n   = iface_q;
		xor_n     = xor_q;
		t0_n      = t0_q;
		t15_n     = t15_q;
		ta1_n     = ta1_q;
		conv_n    = conv_q;
		pend_iface = pend_q;
		res = '0;
		res.byte_kind = scatr_pkg::KIND_SURPLUS;

		if (cnt_q < CNT_W'(MAX_ATR_BYTES)) begin
			cnt_n = cnt_q + CNT_W'(1);
			if (phase_q != PH_TS)
				xor_n = xor_q ^ atr_byte;
			case (phase_q)
				PH_TS: begin
					res.byte_kind = scatr_pkg::KIND_TS;
					conv_n = (atr_byte == scatr_pkg::TS_DIRECT);
					phase_n = PH_T0;
				end
				PH_T0: begin
					res.byte_kind = scatr_pkg::KIND_T0;
					pend_n = atr_byte[7:4];
					hleft_n = atr_byte[3:0];
					htotal_n = atr_byte[3:0];
					grp_n = 6'd1;
					if (atr_byte[7:4] != 4'd0)
						phase_n = PH_IFACE;
					else if (atr_byte[3:0] != 4'd0)
						phase_n = PH_HIST;
					else
						phase_n = PH_TAIL;
				end
				PH_IFACE: begin
					res.group_index = grp_q;
					if (pend_q[0]) begin
						res.byte_kind = scatr_pkg::KIND_TA;
						pend_iface = pend_q & 4'b1110;
						if (grp_q == 6'd1)
							ta1_n = atr_byte;
					end else if (pend_q[1]) begin
						res.byte_kind = scatr_pkg::KIND_TB;
						pend_iface = pend_q & 4'b1100;
					end else if (pend_q[2]) begin
						res.byte_kind = scatr_pkg::KIND_TC;
						pend_iface = pend_q & 4'b1000;
					end else begin
						res.byte_kind = scatr_pkg::KIND_TD;
						// only TD1 and TD2 steer the protocol flags
						if (grp_q == 6'd1) begin
							t0_n  = (proto == scatr_pkg::PROTO_T0);
							t15_n = (proto == scatr_pkg::PROTO_T15);
						end else if (grp_q == 6'd2) begin
							if (proto == scatr_pkg::PROTO_T0)
								t0_n = 1'b1;
							if (proto == scatr_pkg::PROTO_T15)
								t15_n = 1'b1;
						end
						pend_iface = atr_byte[7:4];
						if (grp_q < scatr_pkg::GROUP_MAX)
							grp_n = grp_q + 6'd1;
					end
					pend_n = pend_iface;
					if (iface_q < scatr_pkg::IFACE_MAX)
						iface_n = iface_q + 7'd1;
					if (pend_iface == 4'd0)
						phase_n = (hleft_q != 4'd0) ? PH_HIST : PH_TAIL;
				end
				PH_HIST: begin
					res.byte_kind = scatr_pkg::KIND_HIST;
					if (hleft_q != 4'd0)
						hleft_n = hleft_q - 4'd1;
					if (hleft_n == 4'd0)
						phase_n = PH_TAIL;
				end
				default: begin
					res.byte_kind = (cnt_ext == exp_q && req_q) ?
						scatr_pkg::KIND_CHECK : scatr_pkg::KIND_SURPLUS;
				end
			endcase
		end

		cnt_n_ext = LEN_W'(cnt_n);
		exp_n = LEN_W'(2) + LEN_W'(iface_n) + LEN_W'(htotal_n);

		if (last_byte) begin
			res.summary_valid      = 1'b1;
			res.direct_convention  = conv_n;
			res.check_required     = !t0_n || t15_n;
			res.checksum_good      = (xor_n == 8'd0);
			res.length_good        = (phase_n == PH_HIST || phase_n == PH_TAIL) &&
				(cnt_n_ext == exp_n || cnt_n_ext == exp_n + LEN_W'(1));
			res.offers_t0          = t0_n;
			res.offers_t15         = t15_n;
			res.historical_count   = htotal_n;
			res.clock_rate_factor  = scatr_pkg::fi_decode(ta1_n[7:4]);
			res.baud_adjust_factor = scatr_pkg::di_decode(ta1_n[3:0]);
			// back to the reset state for the next answer
			cnt_n    = '0;
			phase_n  = PH_TS;
			pend_n   = 4'd0;
			grp_n    = 6'd1;
			hleft_n  = 4'd0;
			htotal_n = 4'd0;
			iface_n  = 7'd0;
			xor_n    = 8'd0;
			t0_n     = 1'b1;
			t15_n    = 1'b0;
			ta1_n    = scatr_pkg::TA1_DEFAULT;
			conv_n   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			phase_q  <= PH_TS;
			pend_q   <= 4'd0;
			grp_q    <= 6'd1;
			hleft_q  <= 4'd0;
			htotal_q <= 4'd0;
			iface_q  <= 7'd0;
			xor_q    <= 8'd0;
			t0_q     <= 1'b1;
			t15_q    <= 1'b0;
			ta1_q    <= scatr_pkg::TA1_DEFAULT;
			conv_q   <= 1'b0;
		end else if (take) begin
			cnt_q    <= cnt_n;
			phase_q  <= phase_n;
			pend_q   <= pend_n;
			grp_q    <= grp_n;
			hleft_q  <= hleft_n;
			htotal_q <= htotal_n;
			iface_q  <= iface_n;
			xor_q    <= xor_n;
			t0_q     <= t0_n;
			t15_q    <= t15_n;
			ta1_q    <= ta1_n;
			conv_q   <= conv_n;
		end
	end

endmodule

`default_nettype wire

FILE: design/scatr_outreg.sv
`default_nettype none

module scatr_outreg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          load_valid,
	output logic               load_ready,
	input  wire scatr_pkg::result_t load_data,
	output logic               hold_valid,
	input  wire logic          hold_ready,
	output scatr_pkg::result_t hold_data
);

	logic               valid_q;
	scatr_pkg::result_t data_q;

	// a new result may enter when the register is empty or the held one leaves in the same cycle
	assign load_ready = !valid_q || hold_ready;
	assign hold_valid = valid_q;
	assign hold_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_ready) begin
			valid_q <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_valid && load_ready)
			data_q <= load_data;
	end

endmodule

`default_nettype wire

FILE: design/smartcard_atr_parser.sv
// answer-to-reset parser: one result per received atr byte
// input channel byte_valid/byte_ready carries atr_byte and last_byte; a
// transfer happens when both are high. output channel result_valid/
// result_ready carries the byte classification and, on the last byte, the
// answer summary (summary_valid high, summary fields zero otherwise).
// the result of a byte is registered and presented in the cycle after its transfer.
// throughput: one byte per cycle while byte_ready is high; the parse
// state is updated in the same cycle the byte is taken and the result lands
// in a single output register. while the receiver stalls, byte_ready stays
// high as long as the output register is empty or is being drained in that
// cycle; otherwise the input is held off until result_ready returns.
// after the last byte the parser returns to its idle state, ready for the
// next answer. reset (arst_n low) empties the output register and puts the
// parser in the idle state, expecting TS, with TA1 taken as 0x11.
// bytes beyond MAX_ATR_BYTES are reported as surplus and leave the state
// untouched.
`default_nettype none

module smartcard_atr_parser #(
	parameter int MAX_ATR_BYTES = scatr_pkg::MAX_ATR_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	output logic             byte_ready,
	input  wire logic [7:0]  atr_byte,
	input  wire logic        last_byte,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [3:0]       byte_kind,
	output logic [5:0]       group_index,
	output logic             summary_valid,
	output logic             direct_convention,
	output logic             check_required,
	output logic             checksum_good,
	output logic             length_good,
	output logic             offers_t0,
	output logic             offers_t15,
	output logic [3:0]       historical_count,
	output logic [11:0]      clock_rate_factor,
	output logic [6:0]       baud_adjust_factor
);

	scatr_pkg::result_t step_res;
	scatr_pkg::result_t held_res;
	logic               take;

	assign take = byte_valid && byte_ready;

	scatr_core #(
		.MAX_ATR_BYTES(MAX_ATR_BYTES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.atr_byte (atr_byte),
		.last_byte(last_byte),
		.res      (step_res)
	);

	scatr_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load_valid(byte_valid),
		.load_ready(byte_ready),
		.load_data (step_res),
		.hold_valid(result_valid),
		.hold_ready(result_ready),
		.hold_data (held_res)
	);

	assign byte_kind          = held_res.byte_kind;
	assign group_index        = held_res.group_index;
	assign summary_valid      = held_res.summary_valid;
	assign direct_convention  = held_res.direct_convention;
	assign check_required     = held_res.check_required;
	assign checksum_good      = held_res.checksum_good;
	assign length_good        = held_res.length_good;
	assign offers_t0          = held_res.offers_t0;
	assign offers_t15         = held_res.offers_t15;
	assign historical_count   = held_res.historical_count;
	assign clock_rate_factor  = held_res.clock_rate_factor;
	assign baud_adjust_factor = held_res.baud_adjust_factor;

`ifndef SYNTHESIS
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> byte_ready)
		else $error("input held off while output register empty");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> byte_kind <= scatr_pkg::KIND_SURPLUS)
		else $error("byte kind out of range");

	a_group_only_iface: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (byte_kind == scatr_pkg::KIND_TS || byte_kind == scatr_pkg::KIND_T0 ||
		byte_kind == scatr_pkg::KIND_HIST || byte_kind == scatr_pkg::KIND_CHECK ||
		byte_kind == scatr_pkg::KIND_SURPLUS) |-> group_index == 6'd0)
		else $error("group index on a non-interface byte");

	a_summary_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !summary_valid |-> !direct_convention && !check_required &&
		!checksum_good && !length_good && !offers_t0 && !offers_t15 &&
		historical_count == 4'd0 && clock_rate_factor == 12'd0 &&
		baud_adjust_factor == 7'd0)
		else $error("summary fields set without summary_valid");

	a_check_on_tail: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && byte_kind == scatr_pkg::KIND_CHECK && summary_valid |->
		check_required)
		else $error("check byte reported while TCK not required");
`endif

endmodule

`default_nettype wire
